>>> hw/rtl/shifting_int_queue_with_search_unit_assert.svh
// Assertion macros for the shifting queue RTL.
// Used inside modules that declare clk and rst_n.
`ifndef SHIFTING_INT_QUEUE_WITH_SEARCH_UNIT_ASSERT_SVH
`define SHIFTING_INT_QUEUE_WITH_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define SQS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqs assertion failed");

// next-cycle implication
`define SQS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqs assertion failed");

`endif

>>> hw/rtl/sqs_pkg.sv
// Shared types and constants for the shifting queue with search.
// No dependencies.
package sqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int CAP_W     = 5;
  localparam int CNT_OUT_W = 5;
  localparam int POS_OUT_W = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_ENQ  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SRCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLR  = 3'd4;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic shift;    // every cell but the tail takes its tail-side neighbor's entry; the tail keeps its own
    logic load;     // selected cell takes the enqueued value
    logic capture;  // cells latch their compare result
    logic mshift;   // match flags move one cell toward the head
  } cell_ctl_t;

endpackage

>>> hw/rtl/sqs_cell.sv
// One queue cell: an entry register and a search match flag.
// Depends on sqs_pkg.
module sqs_cell (
  input  logic               clk,
  input  sqs_pkg::cell_ctl_t ctl,
  input  logic               sel,
  input  logic               live,
  input  sqs_pkg::data_t     key,
  input  sqs_pkg::data_t     nbr_data,
  input  logic               nbr_match,
  output sqs_pkg::data_t     data,
  output logic               match
);
  import sqs_pkg::*;

  data_t data_r, data_nxt;
  logic  match_r, match_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.shift) begin
      data_nxt = nbr_data;
    end else if (ctl.load && sel) begin
      data_nxt = key;
    end
  end

  always_comb begin
    match_nxt = match_r;
    if (ctl.capture) begin
      match_nxt = live && (data_r == key);
    end else if (ctl.mshift) begin
      match_nxt = nbr_match;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

>>> hw/rtl/shifting_int_queue_with_search_unit.sv
// Top level of the shifting queue with search: control, count and result register.
// Depends on sqs_pkg, sqs_cell and shifting_int_queue_with_search_unit_assert.svh.
//
//   channel | signals                         | direction
//   in      | in_valid/in_ready, cmd, value   | item in
//   out     | out_valid/out_ready, 6 fields   | result out
//   cfg     | cfg_valid/cfg_ready, cfg_data   | capacity write
//
// Enqueue, dequeue, peek, clear and unused codes: result registered at the accept edge.
// Search: match flags are captured at the accept edge, then walk the cell chain toward the
// head one cell per cycle until a match reaches cell 0 or every live entry is passed.
// No item is taken during a search scan. Reset: synchronous, no clearing pass.
// A result held by out_ready low stalls the input side.
module shifting_int_queue_with_search_unit #(
  parameter int DEPTH = sqs_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sqs_pkg::CMD_W-1:0]      in_cmd,
  input  sqs_pkg::data_t                 in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_status,
  output sqs_pkg::data_t                 out_data,
  output logic [sqs_pkg::POS_OUT_W-1:0]  out_position,
  output logic [sqs_pkg::CNT_OUT_W-1:0]  out_count,
  output logic                           out_is_empty,
  output logic                           out_is_full,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sqs_pkg::CAP_W-1:0]      cfg_data
);
  import sqs_pkg::*;

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW  = (CW > CAP_W) ? CW : CAP_W;
  localparam int PXW = (IW > POS_OUT_W) ? IW : POS_OUT_W;

  state_t state_r, state_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  data_t            out_data_r, out_data_nxt;
  logic [POS_OUT_W-1:0] out_pos_r, out_pos_nxt;
  logic [CNT_OUT_W-1:0] out_count_r, out_count_nxt;
  logic             out_empty_r, out_empty_nxt;
  logic             out_full_r, out_full_nxt;

  cell_ctl_t  ctl;
  data_t      cell_data [DEPTH];
  logic       cell_match [DEPTH];

  logic [LW-1:0]  cap_w, lim_w, cnt_w, cnt_nxt_w;
  logic [PXW-1:0] idx_ext;
  logic           acc, out_free, can_enq, not_empty, scan_done, out_load;

  // capacity clamp and occupancy tests
  assign cap_w     = LW'(cap_r);
  assign lim_w     = (cap_w > LW'(DEPTH)) ? LW'(DEPTH) : cap_w;
  assign cnt_w     = LW'(count_r);
  assign cnt_nxt_w = LW'(count_nxt);
  assign can_enq   = cnt_w < lim_w;
  assign not_empty = count_r != '0;
  assign idx_ext   = PXW'(idx_r);

  assign acc       = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign scan_done = (rem_r == '0) || cell_match[0];
  assign cfg_ready = 1'b1;

  // cell chain
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    data_t nbr_d;
    logic  nbr_m;
    if (gi == DEPTH - 1) begin : g_tail
      assign nbr_d = cell_data[gi];
      assign nbr_m = 1'b0;
    end else begin : g_mid
      assign nbr_d = cell_data[gi+1];
      assign nbr_m = cell_match[gi+1];
    end
    sqs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .sel       (count_r == CW'(gi)),
      .live      (count_r > CW'(gi)),
      .key       (in_value),
      .nbr_data  (nbr_d),
      .nbr_match (nbr_m),
      .data      (cell_data[gi]),
      .match     (cell_match[gi])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && in_cmd == CMD_SRCH) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done && out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready       = 1'b0;
    ctl            = '0;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    out_load       = 1'b0;
    out_status_nxt = 1'b1;
    out_data_nxt   = '0;
    out_pos_nxt    = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = out_free;
        if (acc) begin
          case (in_cmd)
            CMD_ENQ: begin
              out_load = 1'b1;
              if (can_enq) begin
                ctl.load       = 1'b1;
                count_nxt      = count_r + 1'b1;
                out_status_nxt = 1'b0;
              end
            end
            CMD_DEQ: begin
              out_load = 1'b1;
              if (not_empty) begin
                ctl.shift      = 1'b1;
                count_nxt      = count_r - 1'b1;
                out_status_nxt = 1'b0;
                out_data_nxt   = cell_data[0];
              end
            end
            CMD_PEEK: begin
              out_load = 1'b1;
              if (not_empty) begin
                out_status_nxt = 1'b0;
                out_data_nxt   = cell_data[0];
              end
            end
            CMD_SRCH: begin
              ctl.capture = 1'b1;
              idx_nxt     = '0;
              rem_nxt     = count_r;
            end
            CMD_CLR: begin
              out_load       = 1'b1;
              count_nxt      = '0;
              out_status_nxt = 1'b0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          out_load = out_free;
          if (cell_match[0] && rem_r != '0) begin
            out_status_nxt = 1'b0;
            out_pos_nxt    = idx_ext[POS_OUT_W-1:0];
          end
        end else begin
          ctl.mshift = 1'b1;
          idx_nxt    = idx_r + 1'b1;
          rem_nxt    = rem_r - 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_count_nxt = cnt_nxt_w[CNT_OUT_W-1:0];
    out_empty_nxt = count_nxt == '0;
    out_full_nxt  = cnt_nxt_w >= lim_w;
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    rem_r <= rem_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_pos_r    <= out_pos_nxt;
      out_count_r  <= out_count_nxt;
      out_empty_r  <= out_empty_nxt;
      out_full_r   <= out_full_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data     = out_data_r;
  assign out_position = out_pos_r;
  assign out_count    = out_count_r;
  assign out_is_empty = out_empty_r;
  assign out_is_full  = out_full_r;

`include "shifting_int_queue_with_search_unit_assert.svh"

  `SQS_ASSERT_NOW(a_count_max, 1'b1, count_r <= CW'(DEPTH))
  `SQS_ASSERT_NOW(a_scan_blocks_in, state_r == ST_SCAN, !in_ready)
  `SQS_ASSERT_NEXT(a_enq_grows, acc && in_cmd == CMD_ENQ && can_enq,
                   count_r == CW'($past(count_r) + 1'b1))
  `SQS_ASSERT_NEXT(a_search_enters_scan, acc && in_cmd == CMD_SRCH,
                   state_r == ST_SCAN && rem_r == $past(count_r))

endmodule
